// File: rtl/sni_pkg.sv
package sni_pkg;

    // Byte classification codes
    typedef enum logic [1:0] {
        KIND_HDR   = 2'd0,
        KIND_HOST  = 2'd1,
        KIND_TRAIL = 2'd2
    } t_kind;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT_HDR = 3'd1,
        ST_OVER_MAX  = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_BAD_HOST  = 3'd4
    } t_status;

    localparam int unsigned HDR_BYTES = 3;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    // Classified byte passed from front end to back end
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
        logic       short_hdr;
        logic       over_max;
        logic       trunc;
        logic       zero_len;
        logic [7:0] ntype;
        logic [7:0] hlen;
    } t_cls;

endpackage

// File: rtl/sni_stream_if.sv
interface sni_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sni_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] byte_kind;
    logic [7:0] host_char;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] type_byte;
    logic [7:0] host_length;

    modport source (output valid, output byte_kind, output host_char, output done_res,
                    output status, output type_byte, output host_length, input ready);
    modport sink   (input valid, input byte_kind, input host_char, input done_res,
                    input status, input type_byte, input host_length, output ready);
endinterface

// File: rtl/sni_fe.sv
module sni_fe
    import sni_pkg::*;
#(
    parameter int unsigned MAX_HOST_LEN = 253
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sni_in_if.sink    i_in,
    input  logic      i_q_ready,
    output logic      o_push,
    output t_cls      o_cls
);

    logic [1:0]  r_pos, n_pos;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_decl, n_decl;
    logic [15:0] r_seen, n_seen;
    t_kind       kind;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    // Classify the byte and work out the header state it leaves
    always_comb begin
        n_pos  = r_pos;
        n_type = r_type;
        n_decl = r_decl;
        n_seen = r_seen;
        if (32'(r_pos) < HDR_BYTES) begin
            kind = KIND_HDR;
            case (r_pos)
                2'd0:    n_type = i_in.data_byte;
                2'd1:    n_decl = {i_in.data_byte, 8'h00};
                default: n_decl = {r_decl[15:8], i_in.data_byte};
            endcase
            n_pos = r_pos + 2'd1;
        end else if (r_seen < r_decl) begin
            kind   = KIND_HOST;
            n_seen = r_seen + 16'd1;
        end else begin
            kind = KIND_TRAIL;
        end
    end

    always_comb begin
        o_cls.kind      = kind;
        o_cls.data      = (kind == KIND_HOST) ? i_in.data_byte : 8'h00;
        o_cls.last      = i_in.last_byte;
        o_cls.short_hdr = 32'(n_pos) < HDR_BYTES;
        o_cls.over_max  = n_decl > 16'(MAX_HOST_LEN);
        o_cls.trunc     = n_seen < n_decl;
        o_cls.zero_len  = n_decl == 16'd0;
        o_cls.ntype     = n_type;
        o_cls.hlen      = n_decl[7:0];
    end

    // Advance on each transaction; drop all state at the end of an entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_type <= '0;
            r_decl <= '0;
            r_seen <= '0;
        end else if (o_push) begin
            if (i_in.last_byte) begin
                r_pos  <= '0;
                r_type <= '0;
                r_decl <= '0;
                r_seen <= '0;
            end else begin
                r_pos  <= n_pos;
                r_type <= n_type;
                r_decl <= n_decl;
                r_seen <= n_seen;
            end
        end
    end

endmodule

// File: rtl/sni_q.sv
module sni_q
    import sni_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_cls,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cls o_cls
);

    t_cls          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = r_cnt != (Q_AW+1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cls   = r_mem[r_rp];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cls;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH-1)) ? '0 : r_wp + Q_AW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH-1)) ? '0 : r_rp + Q_AW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/sni_be.sv
module sni_be
    import sni_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cls      i_cls,
    output logic      o_pop,
    sni_out_if.source o_out
);

    localparam logic [6:0] LABEL_MAX = 7'd63;
    localparam logic [6:0] LABEL_SAT = 7'd64;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [7:0] HYPH_CHAR = 8'h2D;

    logic [6:0] r_lab, n_lab;
    logic       r_bad, n_bad;
    logic       r_dot, n_dot;

    logic       r_valid;
    t_kind      r_kind;
    logic [7:0] r_char;
    logic       r_done;
    t_status    r_status, n_status;
    logic [7:0] r_ntype;
    logic [7:0] r_hlen, n_hlen;

    logic       is_alnum, is_dot, is_hyph;

    assign o_pop    = i_q_valid && (!r_valid || o_out.ready);
    assign is_dot   = i_cls.data == DOT_CHAR;
    assign is_hyph  = i_cls.data == HYPH_CHAR;
    assign is_alnum = (i_cls.data inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});

    // Apply hostname rules to a host byte
    always_comb begin
        n_lab = r_lab;
        n_bad = r_bad;
        n_dot = r_dot;
        if (i_cls.kind == KIND_HOST) begin
            if (is_dot) begin
                if (r_lab == '0 || r_lab > LABEL_MAX) n_bad = 1'b1;
                n_lab = '0;
                n_dot = 1'b1;
            end else begin
                n_dot = 1'b0;
                if (!is_alnum && !is_hyph) n_bad = 1'b1;
                if (is_hyph && r_lab == '0) n_bad = 1'b1;
                if (r_lab < LABEL_SAT) n_lab = r_lab + 7'd1;
            end
        end
    end

    // Pick the verdict in priority order
    always_comb begin
        n_hlen = 8'h00;
        if (!i_cls.last) begin
            n_status = ST_OK;
        end else if (i_cls.short_hdr) begin
            n_status = ST_SHORT_HDR;
        end else if (i_cls.over_max) begin
            n_status = ST_OVER_MAX;
        end else if (i_cls.trunc) begin
            n_status = ST_TRUNC;
        end else if (i_cls.zero_len || n_bad || n_dot || n_lab == '0 || n_lab > LABEL_MAX) begin
            n_status = ST_BAD_HOST;
        end else begin
            n_status = ST_OK;
            n_hlen   = i_cls.hlen;
        end
    end

    // Hold label state; clear it at the end of an entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lab <= '0;
            r_bad <= 1'b0;
            r_dot <= 1'b0;
        end else if (o_pop) begin
            if (i_cls.last) begin
                r_lab <= '0;
                r_bad <= 1'b0;
                r_dot <= 1'b0;
            end else begin
                r_lab <= n_lab;
                r_bad <= n_bad;
                r_dot <= n_dot;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= i_cls.kind;
            r_char   <= i_cls.data;
            r_done   <= i_cls.last;
            r_status <= n_status;
            r_ntype  <= i_cls.last ? i_cls.ntype : 8'h00;
            r_hlen   <= n_hlen;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.byte_kind   = r_kind;
    assign o_out.host_char   = r_char;
    assign o_out.done_res    = r_done;
    assign o_out.status      = r_status;
    assign o_out.type_byte   = r_ntype;
    assign o_out.host_length = r_hlen;

    a_mid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_done |-> r_status == ST_OK && r_ntype == 8'h00 && r_hlen == 8'h00)
        else $error("verdict fields set on a byte that does not end the entry");

    a_len_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status != ST_OK |-> r_hlen == 8'h00)
        else $error("host length reported with a failing verdict");

    a_char_host: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind != KIND_HOST |-> r_char == 8'h00)
        else $error("character passed on a non-host byte");

    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_cls.last |=> r_lab == '0 && !r_bad && !r_dot)
        else $error("label state not cleared after entry end");

endmodule

// File: rtl/sni_entry_parser_top.sv
// A result for a byte is written into the queue and then into the back end's output
// register, from which it is presented.
// Throughput: one byte per cycle when the output does not stall; a two-entry queue parts
// the header counter in the front end from the label checker in the back end.
// Reset: i_rst_n is synchronous, active low; it clears header and label state,
// empties the queue and drops the output valid. No clearing pass is needed.
module sni_entry_parser_top
    import sni_pkg::*;
#(
    parameter int unsigned MAX_HOST_LEN = 253
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sni_in_if.sink    i_in,
    sni_out_if.source o_out
);

    logic q_ready, push, q_valid, pop;
    t_cls fe_cls, be_cls;

    sni_fe #(.MAX_HOST_LEN(MAX_HOST_LEN)) u_fe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cls     (fe_cls)
    );

    sni_q u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (fe_cls),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cls   (be_cls)
    );

    sni_be u_be (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cls     (be_cls),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// File: tb/tb_sni_entry_parser_top.sv
`timescale 1ns / 1ps
module tb_sni_entry_parser_top;
    import sni_pkg::*;

    localparam int unsigned MAX_LEN      = 253;
    localparam int unsigned LABEL_LIMIT  = 63;
    localparam int unsigned LABEL_CAP    = 64;
    localparam logic [7:0]  DOT          = 8'h2E;
    localparam logic [7:0]  HYPHEN       = 8'h2D;
    localparam int unsigned RANDOM_BYTES = 1000;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_AT      = 120;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned PAUSE_AT     = 600;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       done;
        t_status    st;
        logic [7:0] ntype;
        logic [7:0] hlen;
    } t_sni_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sni_in_if  in_if ();
    sni_out_if out_if ();

    sni_entry_parser_top #(
        .MAX_HOST_LEN (MAX_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Parser state mirrored from the block
    logic [1:0]  hdr_pos   = '0;
    logic [7:0]  ent_type  = '0;
    logic [15:0] decl_len  = '0;
    logic [15:0] host_cnt  = '0;
    logic [6:0]  label_run = '0;
    logic        name_bad  = 1'b0;
    logic        ends_dot  = 1'b0;

    t_in_item    pending_q[$];
    t_sni_result verdict_q[$];
    logic [7:0]  entry_q[$];
    logic [7:0]  host_q[$];

    int unsigned total_bytes = 0;
    int unsigned sent_count  = 0;
    int unsigned in_count    = 0;
    int unsigned out_count   = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left   = 0;
    int unsigned err_count   = 0;
    logic        hold_done   = 1'b0;
    logic        tx_pause    = 1'b0;
    logic        pause_done  = 1'b0;

    always #5 i_clk = ~i_clk;

    // Work out the result of one byte and advance the mirrored state
    function automatic t_sni_result parse_byte(input logic [7:0] b, input logic last);
        t_sni_result r;
        logic        alnum;
        r = '{kind: KIND_HDR, ch: 8'h00, done: 1'b0, st: ST_OK, ntype: 8'h00, hlen: 8'h00};
        if (hdr_pos < 2'(HDR_BYTES)) begin
            case (hdr_pos)
                2'd0: ent_type = b;
                2'd1: decl_len = {b, 8'h00};
                default: decl_len[7:0] = b;
            endcase
            hdr_pos = hdr_pos + 2'd1;
        end else if (host_cnt < decl_len) begin
            r.kind = KIND_HOST;
            r.ch   = b;
            if (b == DOT) begin
                // close the label
                if (label_run == 0 || label_run > LABEL_LIMIT) name_bad = 1'b1;
                label_run = '0;
                ends_dot  = 1'b1;
            end else begin
                alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                        (b >= 8'h61 && b <= 8'h7A);
                ends_dot = 1'b0;
                if (!alnum && b != HYPHEN) name_bad = 1'b1;
                if (b == HYPHEN && label_run == 0) name_bad = 1'b1;
                if (label_run < LABEL_CAP) label_run = label_run + 7'd1;
            end
            host_cnt = host_cnt + 16'd1;
        end else begin
            r.kind = KIND_TRAIL;
        end
        if (last) begin
            r.done  = 1'b1;
            r.ntype = ent_type;
            if (hdr_pos < 2'(HDR_BYTES)) r.st = ST_SHORT_HDR;
            else if (decl_len > MAX_LEN) r.st = ST_OVER_MAX;
            else if (host_cnt < decl_len) r.st = ST_TRUNC;
            else if (decl_len == 0 || name_bad || ends_dot || label_run == 0 ||
                     label_run > LABEL_LIMIT) r.st = ST_BAD_HOST;
            else begin
                r.st   = ST_OK;
                r.hlen = decl_len[7:0];
            end
            // start afresh for the next entry
            hdr_pos   = '0;
            ent_type  = '0;
            decl_len  = '0;
            host_cnt  = '0;
            label_run = '0;
            name_bad  = 1'b0;
            ends_dot  = 1'b0;
        end
        return r;
    endfunction

    function automatic t_idle idle_mode();
        if (in_count < 300) return IDLE_NONE;
        if (in_count < 550) return IDLE_TX;
        if (in_count < 800) return IDLE_RX;
        return IDLE_BOTH;
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 69);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        if (r < 62) return 8'h30 + 8'(r - 52);
        return HYPHEN;
    endfunction

    task automatic put(input logic [7:0] b);
        entry_q.push_back(b);
    endtask

    task automatic put_header(input logic [7:0] kind_byte, input logic [15:0] len);
        put(kind_byte);
        put(len[15:8]);
        put(len[7:0]);
    endtask

    // Move the entry onto the send queue, marking its final byte
    task automatic close_entry();
        t_in_item it;
        for (int i = 0; i < entry_q.size(); i++) begin
            it.data = entry_q[i];
            it.last = (i == entry_q.size() - 1);
            pending_q.push_back(it);
        end
        entry_q.delete();
    endtask

    // Build a plausible host name of a few labels, now and then a long one
    task automatic build_host();
        int         nlab;
        int         len;
        logic [7:0] c;
        host_q.delete();
        nlab = $urandom_range(1, 4);
        for (int i = 0; i < nlab; i++) begin
            if (i > 0) host_q.push_back(DOT);
            len = ($urandom_range(0, 99) < 5) ? $urandom_range(60, 66) : $urandom_range(1, 10);
            for (int j = 0; j < len; j++) begin
                c = pick_char();
                if (j == 0 && c == HYPHEN) c = 8'h78;
                host_q.push_back(c);
            end
        end
    endtask

    task automatic put_host();
        foreach (host_q[i]) put(host_q[i]);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Driver: offer pending bytes, hold each until taken
    always @(posedge i_clk) begin
        t_in_item it;
        logic     offer;
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.data_byte <= 8'h00;
            in_if.last_byte <= 1'b0;
        end else if (!(in_if.valid && !in_if.ready)) begin
            offer = 1'b0;
            if (tx_pause) begin
                // resume once every byte sent so far has its result
                if (!in_if.valid && out_count == in_count) begin
                    tx_pause   <= 1'b0;
                    pause_done <= 1'b1;
                end
            end else if (!pause_done && sent_count == PAUSE_AT) begin
                tx_pause <= 1'b1;
            end else if (pending_q.size() > 0) begin
                case (idle_mode())
                    IDLE_TX:   offer = ($urandom_range(0, 99) >= 55);
                    IDLE_BOTH: offer = ($urandom_range(0, 99) >= 27);
                    default:   offer = 1'b1;
                endcase
            end
            if (offer) begin
                it = pending_q.pop_front();
                in_if.valid     <= 1'b1;
                in_if.data_byte <= it.data;
                in_if.last_byte <= it.last;
                sent_count      <= sent_count + 1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Count down the one long receiver hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && out_count >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: check results, predict taken bytes, drive ready
    always @(posedge i_clk) begin
        t_sni_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            // compare the result transaction with the oldest verdict
            if (out_if.valid && out_if.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0h char %0h done %0b",
                             $time, out_if.byte_kind, out_if.host_char, out_if.done_res);
                    err_count++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("byte_kind", 8'(want.kind), 8'(out_if.byte_kind));
                    check_field("host_char", want.ch, out_if.host_char);
                    check_field("done_res", 8'(want.done), 8'(out_if.done_res));
                    check_field("status", 8'(want.st), 8'(out_if.status));
                    check_field("type_byte", want.ntype, out_if.type_byte);
                    check_field("host_length", want.hlen, out_if.host_length);
                end
                out_count <= out_count + 1;
            end
            // predict the input transaction taken at this edge
            if (in_if.valid && in_if.ready) begin
                verdict_q.push_back(parse_byte(in_if.data_byte, in_if.last_byte));
                in_count <= in_count + 1;
            end
            // hold off during the long stretch, otherwise stall as the phase says
            if (hold_left > 0 || (!hold_done && out_count >= HOLD_AT)) begin
                out_if.ready <= 1'b0;
            end else begin
                case (idle_mode())
                    IDLE_RX:   out_if.ready <= ($urandom_range(0, 99) >= 55);
                    IDLE_BOTH: out_if.ready <= ($urandom_range(0, 99) >= 27);
                    default:   out_if.ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int r;
        int n;
        i_rst_n = 1'b0;

        // Directed entries
        put(8'hFF);                          // header cut after the type byte
        close_entry();
        put(8'h00); put(8'h00);              // header cut inside the length
        close_entry();
        put_header(8'h00, 16'd0);            // empty host
        close_entry();
        put_header(8'h7A, 16'd1); put(8'h61);
        close_entry();
        put_header(8'h80, 16'hFFFF); put(8'hFF);   // declared length over the maximum
        close_entry();
        put_header(8'h01, 16'd3); put(8'h61);      // body shorter than declared
        close_entry();
        put_header(8'h02, 16'd2); put(HYPHEN); put(8'h61); put(8'h55);   // hyphen first, trailer
        close_entry();

        // Random entries, mostly well formed
        while (pending_q.size() < 24 + RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                n = $urandom_range(1, 2);
                for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
            end else if (r < 70) begin
                build_host();
                put_header(8'($urandom_range(0, 255)), 16'(host_q.size()));
                put_host();
                if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
                end
            end else if (r < 80) begin
                build_host();
                case ($urandom_range(0, 4))
                    0: host_q[$urandom_range(0, host_q.size() - 1)] = 8'($urandom_range(0, 255));
                    1: host_q.push_front(DOT);
                    2: host_q.push_back(DOT);
                    3: begin
                        host_q.push_back(DOT);
                        host_q.push_back(DOT);
                        host_q.push_back(pick_char());
                        host_q.push_back(8'h61);
                    end
                    default: begin
                        host_q.push_back(DOT);
                        host_q.push_back(HYPHEN);
                        host_q.push_back(8'h61);
                    end
                endcase
                put_header(8'($urandom_range(0, 255)), 16'(host_q.size()));
                put_host();
            end else if (r < 87) begin
                build_host();
                put_header(8'($urandom_range(0, 255)),
                           16'(host_q.size() + $urandom_range(1, 5)));
                put_host();
            end else if (r < 93) begin
                n = ($urandom_range(0, 3) == 0) ? MAX_LEN + 1 : $urandom_range(MAX_LEN + 1, 65535);
                put_header(8'($urandom_range(0, 255)), 16'(n));
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
            end else begin
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
            end
            close_entry();
        end
        total_bytes = pending_q.size();

        // Reset once
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain, then let the pipeline settle
        while (in_count != total_bytes || out_count != in_count) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && verdict_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
